/* hw/rtl/assert_macros.svh */
// assertion macros shared by the deframer rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion %m failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition %m");

`endif

/* hw/rtl/bsfd_pkg.sv */
// types and constants of the byte stuffed frame deframer
// no dependencies; imported by every deframer module
`default_nettype none

package bsfd_pkg;

  localparam logic [7:0] FLAG_RST     = 8'h7e;
  localparam logic [7:0] ESCAPE_RST   = 8'h7f;
  localparam logic [7:0] FLAG_ESC_RST = 8'h80;
  localparam logic [7:0] ESC_ESC_RST  = 8'h81;

  // register index, from paddr[3:2]
  localparam logic [1:0] REG_FLAG     = 2'd0;
  localparam logic [1:0] REG_ESCAPE   = 2'd1;
  localparam logic [1:0] REG_FLAG_ESC = 2'd2;
  localparam logic [1:0] REG_ESC_ESC  = 2'd3;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_DATA,
    MODE_ESC
  } mode_t;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_DATA,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } qitem_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] flag_escape_code;
    logic [7:0] escape_escape_code;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/bsfd_front.sv */
// front end: tracks hunt / in-frame / escape mode and turns raw bytes into ops
// depends on bsfd_pkg
`default_nettype none

module bsfd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsfd_pkg::cfg_t  cfg,
  input  wire logic            byte_valid,
  input  wire logic [7:0]      rx_byte,
  output logic                 push,
  output bsfd_pkg::qitem_t     item
);
  import bsfd_pkg::*;

  mode_t mode_r, mode_nxt;
  logic  nonempty_r, nonempty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HUNT;
      nonempty_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    nonempty_nxt = nonempty_r;
    if (byte_valid) begin
      case (mode_r)
        MODE_DATA: begin
          if (rx_byte == cfg.flag_value) begin
            // a flag in an empty frame is ignored
            if (nonempty_r) mode_nxt = MODE_HUNT;
          end else if (rx_byte == cfg.escape_value) begin
            mode_nxt = MODE_ESC;
          end else begin
            nonempty_nxt = 1'b1;
          end
        end
        MODE_ESC: begin
          if (rx_byte == cfg.flag_escape_code || rx_byte == cfg.escape_escape_code) begin
            mode_nxt     = MODE_DATA;
            nonempty_nxt = 1'b1;
          end else begin
            mode_nxt = MODE_HUNT;
          end
        end
        default: begin
          if (rx_byte == cfg.flag_value) begin
            mode_nxt     = MODE_DATA;
            nonempty_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    push      = 1'b0;
    item.op   = OP_DATA;
    item.data = rx_byte;
    if (byte_valid) begin
      case (mode_r)
        MODE_DATA: begin
          if (rx_byte == cfg.flag_value) begin
            push    = nonempty_r;
            item.op = OP_CLOSE;
          end else if (rx_byte != cfg.escape_value) begin
            push = 1'b1;
          end
        end
        MODE_ESC: begin
          if (rx_byte == cfg.flag_escape_code) begin
            push      = 1'b1;
            item.data = cfg.flag_value;
          end else if (rx_byte == cfg.escape_escape_code) begin
            push      = 1'b1;
            item.data = cfg.escape_value;
          end
        end
        default: begin
          if (rx_byte == cfg.flag_value) begin
            push    = 1'b1;
            item.op = OP_OPEN;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bsfd_queue.sv */
// two entry fifo of ops between front and back end
// depends on bsfd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bsfd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bsfd_pkg::qitem_t  push_item,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output bsfd_pkg::qitem_t       head
);
  import bsfd_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  qitem_t         mem [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full      = (count_r == CW'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CW'(QDEPTH))
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !not_empty)
  `ASSERT_NEVER(a_push_full, clk, rst_n, push && full)

endmodule

`default_nettype wire

/* hw/rtl/bsfd_back.sv */
// back end: frame counters, running sum and the output record register
// depends on bsfd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bsfd_back #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire bsfd_pkg::qitem_t  q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,
  output logic [0:0]             out_tuser
);
  import bsfd_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          ovf_r, ovf_nxt;

  logic          valid_r;
  logic          kind_r;
  logic [7:0]    payload_r, pos_r, bsum_r, check_r;
  logic [8:0]    len_r;
  logic          oflag_r;

  logic          emit;
  logic [CW+8:0] cnt_ext;
  logic          frame_full;

  assign q_pop      = q_not_empty && (!valid_r || out_tready);
  assign cnt_ext    = {9'd0, count_r};
  assign frame_full = (count_r == CW'(MAX_FRAME));

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    last_nxt  = last_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    if (q_pop) begin
      case (q_head.op)
        OP_OPEN: begin
          count_nxt = '0;
          sum_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        OP_DATA: begin
          if (frame_full) begin
            ovf_nxt = 1'b1;
          end else begin
            emit      = 1'b1;
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + q_head.data;
            last_nxt  = q_head.data;
          end
        end
        OP_CLOSE: begin
          emit      = 1'b1;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      last_r  <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      last_r  <= last_nxt;
      ovf_r   <= ovf_nxt;
      if (emit) valid_r <= 1'b1;
      else if (out_tready) valid_r <= 1'b0;
    end
  end

  // record payload, zero in the fields that do not apply
  always_ff @(posedge clk) begin
    if (emit) begin
      if (q_head.op == OP_CLOSE) begin
        kind_r    <= 1'b1;
        payload_r <= '0;
        pos_r     <= '0;
        len_r     <= cnt_ext[8:0];
        bsum_r    <= sum_r - last_r;
        check_r   <= last_r;
        oflag_r   <= ovf_r;
      end else begin
        kind_r    <= 1'b0;
        payload_r <= q_head.data;
        pos_r     <= cnt_ext[7:0];
        len_r     <= '0;
        bsum_r    <= '0;
        check_r   <= '0;
        oflag_r   <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {6'd0, oflag_r, check_r, bsum_r, len_r, pos_r, payload_r};

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CW'(MAX_FRAME))
  `ASSERT_CLK(a_full_sets_ovf, clk, rst_n,
              (q_pop && q_head.op == OP_DATA && frame_full) |=> ovf_r)

endmodule

`default_nettype wire

/* hw/rtl/byte_stuffed_frame_deframer.sv */
// byte stuffed frame deframer
// One raw byte per transaction enters on in_*; records leave on out_*.
// out_tuser[0] is the record kind: 0 data byte, 1 end of frame. Data
// records carry the unescaped byte and its index; end records carry the
// frame length, the sum of all bytes but the last, the last byte and the
// overflow flag. Unused fields of a record read as zero.
// An accepted byte's op is written into the op queue and then popped
// into the output register as a record, where the receiver takes it;
// the block takes one byte every cycle as long as out_tready is high,
// since the op queue moves one push and one pop per cycle.
// When the receiver stalls the output register holds its record, the
// two entry op queue fills and in_tready falls once it is full.
// Reset returns to hunt mode, empties the queue, clears the counters and
// loads the default flag 0x7e, escape 0x7f and codes 0x80 / 0x81.
// Registers on cfg_* (APB, byte address 4*index): flag, escape, flag
// escape code, escape escape code; write them only while idle.
// depends on bsfd_pkg, bsfd_front, bsfd_queue, bsfd_back
`default_nettype none

module byte_stuffed_frame_deframer #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] payload_byte, [15:8] byte_position, [24:16] frame_length,
  // [32:25] body_sum, [40:33] check_byte, [41] overflowed, rest zero
  output logic [47:0]      out_tdata,
  output logic [0:0]       out_tuser,    // [0] record_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bsfd_pkg::*;

  cfg_t   cfg_r;
  logic   cfg_wr;
  logic   push, q_full, q_not_empty, q_pop;
  qitem_t push_item, q_head;
  logic [7:0] rd_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value         <= FLAG_RST;
      cfg_r.escape_value       <= ESCAPE_RST;
      cfg_r.flag_escape_code   <= FLAG_ESC_RST;
      cfg_r.escape_escape_code <= ESC_ESC_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FLAG:     cfg_r.flag_value         <= cfg_pwdata[7:0];
        REG_ESCAPE:   cfg_r.escape_value       <= cfg_pwdata[7:0];
        REG_FLAG_ESC: cfg_r.flag_escape_code   <= cfg_pwdata[7:0];
        REG_ESC_ESC:  cfg_r.escape_escape_code <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FLAG:     rd_sel = cfg_r.flag_value;
      REG_ESCAPE:   rd_sel = cfg_r.escape_value;
      REG_FLAG_ESC: rd_sel = cfg_r.flag_escape_code;
      REG_ESC_ESC:  rd_sel = cfg_r.escape_escape_code;
      default:      rd_sel = '0;
    endcase
  end
  assign cfg_prdata = {24'd0, rd_sel};

  assign in_tready = !q_full;

  bsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_tvalid && in_tready),
    .rx_byte    (in_tdata),
    .push       (push),
    .item       (push_item)
  );

  bsfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bsfd_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire
